[sv/ldtr_pkg.sv]
// shared types, constants and byte builders for the two-wire led refresh engine
// no dependencies
package ldtr_pkg;

   localparam int DIGIT_COUNT_DEF = 4;

   localparam logic [1:0] ACT_TICK    = 2'd0;
   localparam logic [1:0] ACT_REQUEST = 2'd1;
   localparam logic [1:0] ACT_DIGIT   = 2'd2;

   localparam logic [7:0] CMD_CONTROL = 8'h48;
   localparam logic [7:0] CMD_DIGIT   = 8'h68;
   localparam logic [3:0] DISPLAY_ON  = 4'h1;
   localparam logic [3:0] MAX_BRIGHT  = 4'd7;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef struct packed {
      logic       step;
      logic       tick;
      logic       request;
      logic       dio_in;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } eng_ctl_type;

   typedef struct packed {
      logic clk_level;
      logic dio_level;
      logic dio_drive;
      logic busy;
      logic ack_bit;
      logic frame_done;
      logic request_refused;
   } eng_sts_type;

   function automatic logic [7:0] control_byte(input logic [3:0] brightness);
      logic [3:0] b;
      b = (brightness > MAX_BRIGHT) ? 4'd0 : brightness;
      return {b, DISPLAY_ON};
   endfunction

   function automatic logic [7:0] digit_cmd(input logic [2:0] slot);
      return CMD_DIGIT + {4'd0, slot, 1'b0};
   endfunction

endpackage

[sv/ldtr_engine.sv]
// bit-level frame sequencer: start, two acked bytes, stop, one phase per tick
// depends on ldtr_pkg
module ldtr_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  ldtr_pkg::eng_ctl_type ctl,
   output ldtr_pkg::eng_sts_type sts
);
   import ldtr_pkg::*;

   localparam logic [4:0] PH_IDLE        = 5'd0;
   localparam logic [4:0] PH_START_FIRST = 5'd1;
   localparam logic [4:0] PH_START_LAST  = 5'd6;
   localparam logic [4:0] PH_BIT_FIRST   = 5'd7;
   localparam logic [4:0] PH_BIT_LAST    = 5'd10;
   localparam logic [4:0] PH_STOP_FIRST  = 5'd11;
   localparam logic [4:0] PH_STOP_LAST   = 5'd17;
   localparam logic [3:0] ACK_BIT_IDX    = 4'd8;

   logic [4:0] phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic       byte_ff, byte_in;
   logic [7:0] shift_ff, shift_in;
   logic       ack_ff, ack_in;
   logic       clk_ff, clk_in;
   logic       dio_ff, dio_in;
   logic       drv_ff, drv_in;
   logic       done, refused;
   logic       busy;
   logic       ack_slot;
   logic [1:0] sub;
   logic [4:0] sub_full;

   assign busy     = phase_ff != PH_IDLE;
   assign ack_slot = bit_ff >= ACK_BIT_IDX;
   assign sub_full = phase_ff - PH_BIT_FIRST;
   assign sub      = sub_full[1:0];

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      ack_in   = ack_ff;
      clk_in   = clk_ff;
      dio_in   = dio_ff;
      drv_in   = drv_ff;
      done     = 1'b0;
      refused  = 1'b0;
      if (ctl.request) begin
         if (busy) begin
            refused = 1'b1;
         end else begin
            phase_in = PH_START_FIRST;
            bit_in   = 4'd0;
            byte_in  = 1'b0;
            shift_in = ctl.first_byte;
         end
      end else if (ctl.tick && busy) begin
         if (phase_ff >= PH_START_FIRST && phase_ff <= PH_START_LAST) begin
            clk_in = phase_ff <= 5'd4;
            if (phase_ff == 5'd2 || phase_ff == 5'd3) dio_in = 1'b1;
            if (phase_ff >= 5'd4) dio_in = 1'b0;
            drv_in   = 1'b1;
            phase_in = (phase_ff == PH_START_LAST) ? PH_BIT_FIRST : phase_ff + 5'd1;
         end else if (phase_ff >= PH_BIT_FIRST && phase_ff <= PH_BIT_LAST) begin
            clk_in = sub == 2'd2;
            if (sub == 2'd0 && ack_slot) begin
               drv_in = 1'b0;
               dio_in = 1'b1;
            end else if (sub == 2'd1) begin
               if (ack_slot) begin
                  ack_in = ctl.dio_in;
                  dio_in = 1'b0;
               end else begin
                  dio_in   = shift_ff[7];
                  shift_in = {shift_ff[6:0], 1'b0};
               end
               drv_in = 1'b1;
            end
            if (sub != 2'd3) begin
               phase_in = phase_ff + 5'd1;
            end else if (!ack_slot) begin
               bit_in   = bit_ff + 4'd1;
               phase_in = PH_BIT_FIRST;
            end else if (!byte_ff) begin
               byte_in  = 1'b1;
               bit_in   = 4'd0;
               shift_in = ctl.second_byte;
               phase_in = PH_BIT_FIRST;
            end else begin
               phase_in = PH_STOP_FIRST;
            end
         end else if (phase_ff >= PH_STOP_FIRST && phase_ff <= PH_STOP_LAST) begin
            drv_in = 1'b1;
            if (phase_ff == 5'd13 || phase_ff == 5'd14) begin
               clk_in = 1'b0;
               dio_in = 1'b0;
            end
            if (phase_ff == 5'd15) clk_in = 1'b1;
            if (phase_ff >= 5'd16) begin
               clk_in = 1'b1;
               dio_in = 1'b1;
            end
            if (phase_ff != PH_STOP_LAST) begin
               phase_in = phase_ff + 5'd1;
            end else begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end else begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 4'd0;
         byte_ff  <= 1'b0;
         shift_ff <= 8'd0;
         ack_ff   <= 1'b0;
         clk_ff   <= 1'b1;
         dio_ff   <= 1'b1;
         drv_ff   <= 1'b1;
      end else if (ctl.step) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         ack_ff   <= ack_in;
         clk_ff   <= clk_in;
         dio_ff   <= dio_in;
         drv_ff   <= drv_in;
      end
   end

   always_comb begin
      sts.clk_level       = clk_in;
      sts.dio_level       = dio_in;
      sts.dio_drive       = drv_in;
      sts.busy            = phase_in != PH_IDLE;
      sts.ack_bit         = ack_in;
      sts.frame_done      = done;
      sts.request_refused = refused;
   end

endmodule

[sv/led_driver_twowire_refresh.sv]
// top level of the two-wire led refresh engine: digit store, brightness, result register
// depends on ldtr_pkg and ldtr_engine
//
// Takes one word per clock. Each word is a 5 us tick, a frame request or a digit
// write, and gives exactly one result word with the line levels after it. All
// per-word work is one pass of logic into the result register; req_tready is high
// whenever that register is empty or being read, so with rsp_tready held high a
// word is accepted every cycle. A frame is 6 start ticks, 2 x 9 x 4 bit ticks and 7
// stop ticks; the control frame comes first, then DIGIT_COUNT digit frames. The user
// writes brightness on the csr channel only while no frame is running; the block does not enforce it.
module led_driver_twowire_refresh #(
   parameter int DIGIT_COUNT = ldtr_pkg::DIGIT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // digit_index[1:0], digit_value[9:2], dio_in[10], zero fill
   input  logic [ldtr_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // clk_level[0], dio_level[1], dio_drive[2], busy_res[3], ack_bit[4],
   // frame_done[5], request_refused[6], zero fill
   output logic [ldtr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [3:0]                      csr_data
);
   import ldtr_pkg::*;

   logic [3:0]  bright_ff;
   logic [2:0]  slot_ff, slot_in;
   logic [7:0]  store_ff [DIGIT_COUNT];
   logic        rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic        accept;
   logic [1:0]  action;
   logic [1:0]  digit_index;
   logic [7:0]  digit_value;
   logic        is_control;
   logic [7:0]  stored_byte;
   eng_ctl_type ctl;
   eng_sts_type sts;

   assign action      = req_tuser;
   assign digit_index = req_tdata[1:0];
   assign digit_value = req_tdata[9:2];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign is_control = int'(slot_ff) >= DIGIT_COUNT;

   always_comb begin
      stored_byte = 8'd0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (int'(slot_ff) == i) stored_byte = store_ff[i];
      end
   end

   always_comb begin
      ctl.step        = accept;
      ctl.tick        = action == ACT_TICK;
      ctl.request     = action == ACT_REQUEST;
      ctl.dio_in      = req_tdata[10];
      ctl.first_byte  = is_control ? CMD_CONTROL : digit_cmd(slot_ff);
      ctl.second_byte = is_control ? control_byte(bright_ff) : stored_byte;
   end

   ldtr_engine u_engine (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts)
   );

   always_comb begin
      slot_in = slot_ff;
      if (sts.frame_done) begin
         slot_in = is_control ? 3'd0 : slot_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff    <= 4'd0;
         slot_ff      <= 3'd5;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIGIT_COUNT; i++) store_ff[i] <= 8'd0;
      end else begin
         if (csr_valid) bright_ff <= csr_data;
         if (accept) begin
            slot_ff <= slot_in;
            if (action == ACT_DIGIT) begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  if (int'(digit_index) == i) store_ff[i] <= digit_value;
               end
            end
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {1'b0, sts.request_refused, sts.frame_done, sts.ack_bit,
                         sts.busy, sts.dio_drive, sts.dio_level, sts.clk_level};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
